### hw/rtl/dnad_pkg.sv
// dinucleotide abundance difference: shared types and constants
// used by dinucleotide_abundance_difference and its testbench
`timescale 1ns / 1ps
package dnad_pkg;

  localparam int RATIO_W = 24;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam logic [2:0] NO_BASE = 3'd4;

  typedef enum logic {
    OP_REFERENCE = 1'b0,
    OP_WINDOW    = 1'b1
  } opcode_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] base_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [RATIO_W-1:0] difference;
    logic               short_window;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_COUNT,
    ST_CLEAR,
    ST_RD,
    ST_MUL,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } state_t;

  function automatic logic [2:0] base_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      8'h41:   r = 3'd0;
      8'h43:   r = 3'd1;
      8'h54:   r = 3'd2;
      8'h47:   r = 3'd3;
      default: r = NO_BASE;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/dnad_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`timescale 1ns / 1ps
module dnad_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/dinucleotide_abundance_difference.sv
// dinucleotide relative abundance signature difference, top level
// depends on dnad_pkg and dnad_ram
`timescale 1ns / 1ps
// usage: drive start with an item (opcode, base_char, last) while busy is low.
// characters are taken one per cycle while busy is low; one that closes a pair
// of bases also holds busy in the cycle after, while the complement pair goes
// through the 16 entry pair count ram, which is read, incremented and written
// back, with forwarding on back to back hits of the same pair entry.
// on an item marked last the block goes busy, waits for pair updates to drain
// and works through the 16 ratios one at a time: a read state, three multiply
// steps, a bit serial divider that ends early when a ratio is zero or
// saturates, and an accumulate state; then it clears the pair counts.
// a reference pass writes the ratios into the reference ram and gives no
// result; a window pass gives one result beat, one cycle wide.
// the receiver cannot stall; results are not held.
// reset: rst (synchronous) clears control state and then busy stays high for
// a pass over all 16 entries that zeroes both rams.
module dinucleotide_abundance_difference #(
  parameter int MAX_LENGTH      = 1048576,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  dnad_pkg::in_item_t  item,
  output logic                busy,
  output logic                done,
  output dnad_pkg::out_item_t result
);
  import dnad_pkg::*;

  localparam int CW  = $clog2(MAX_LENGTH + 1);
  localparam int NW  = 2 * CW + CW + 1 + RATIO_FRAC_BITS;
  localparam int DW  = 3 * CW;
  localparam logic [CW-1:0] MAXC = CW'(MAX_LENGTH);

  state_t state, state_next;
  logic [3:0] idx;
  logic ref_pass, clr_init;
  logic [2:0] prev;
  logic [CW-1:0] ccount;
  logic [CW-1:0] bcnt [4];

  // pair count ram
  logic pc_we;
  logic [3:0] pc_wa, pc_ra;
  logic [CW-1:0] pc_wd, pc_rd;
  // reference ratio ram
  logic rr_we;
  logic [3:0] rr_wa;
  logic [RATIO_W-1:0] rr_wd, rr_rd;

  dnad_ram #(.WIDTH(CW), .DEPTH(16)) u_pairs (
    .clk(clk), .we(pc_we), .waddr(pc_wa), .wdata(pc_wd), .raddr(pc_ra), .rdata(pc_rd));
  dnad_ram #(.WIDTH(RATIO_W), .DEPTH(16)) u_refs (
    .clk(clk), .we(rr_we), .waddr(rr_wa), .wdata(rr_wd), .raddr(idx), .rdata(rr_rd));

  logic acc_in;
  logic [2:0] code;
  logic pair_ok;
  assign acc_in  = start && !busy;
  assign code    = base_code(item.base_char);
  assign pair_ok = acc_in && (ccount < MAXC) && prev != NO_BASE && code != NO_BASE;

  // counting: forward pair read first, complement pair issued as second op
  // two-op pipeline: stage a reads entry, stage b writes entry+1 with forwarding
  logic s1_v, s2_v;
  logic [3:0] s1_a, s2_a;
  logic [3:0] fwd_a, cmp_a;
  logic [3:0] cmp_a_q;
  logic cmp_pend;
  assign fwd_a = {prev[1:0], code[1:0]};
  assign cmp_a = {prev[1:0] ^ 2'd2, code[1:0] ^ 2'd2};

  // write stage
  logic [CW-1:0] s2_val;
  logic [CW-1:0] cur;
  always_comb begin
    cur = pc_rd;
    if (s2_v && s2_a == s1_a) cur = s2_val;
  end

  // pending complement issues when next input is blocked
  assign busy = (state != ST_COUNT) || cmp_pend;

  always_comb begin
    pc_ra = fwd_a;
    if (cmp_pend) pc_ra = cmp_a_q;
    else if (state == ST_RD) pc_ra = idx;
  end

  always_comb begin
    pc_we = 1'b0;
    pc_wa = s1_a;
    pc_wd = cur + CW'(1);
    if (state == ST_CLEAR) begin
      pc_we = 1'b1;
      pc_wa = idx;
      pc_wd = '0;
    end else if (s1_v) begin
      pc_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      cmp_pend <= 1'b0;
    end else begin
      s1_v <= pair_ok || cmp_pend;
      s1_a <= cmp_pend ? cmp_a_q : fwd_a;
      s2_v <= s1_v && state != ST_CLEAR;
      s2_a <= s1_a;
      s2_val <= cur + CW'(1);
      cmp_pend <= pair_ok;
      cmp_a_q <= cmp_a;
    end
  end

  // ratio datapath
  logic [CW-1:0] d, b1, b2, len;
  logic [2*CW-1:0] p1;    // L*L
  logic [2*CW-1:0] p2;    // (L-1)*b1
  logic [2*CW-1:0] pl1;   // low half of L*L times d
  logic [2*CW-1:0] pl2;   // low half of (L-1)*b1 times b2
  logic [NW-1:0] num_full;
  logic [DW-1:0] den_full;
  logic [DW-1:0] den;
  logic [NW-1:0] rem;
  logic [RATIO_W-1:0] q;
  logic [4:0] bitn;
  logic [1:0] mstep;
  logic [RATIO_W-1:0] wr;
  logic zero_case, sat_case;
  logic [RATIO_W+4:0] sum;
  logic [NW+RATIO_W-1:0] den_sh;
  logic [NW+RATIO_W:0] trial;

  // 2*L*L*d scaled by the fraction bits, high half product added to the low one
  assign num_full = (NW'((2*CW)'(p1[2*CW-1:CW]) * (2*CW)'(d)) << (CW + RATIO_FRAC_BITS + 1))
                  + (NW'(pl1) << (RATIO_FRAC_BITS + 1));
  assign den_full = (DW'((2*CW)'(p2[2*CW-1:CW]) * (2*CW)'(b2)) << CW) + DW'(pl2);

  assign den_sh = (NW+RATIO_W)'(den) << bitn;
  assign trial = {1'b0, (NW+RATIO_W)'(rem)} - {1'b0, den_sh};

  logic [RATIO_W-1:0] diff;
  assign diff = (rr_rd >= wr) ? rr_rd - wr : wr - rr_rd;

  always_comb begin
    state_next = state;
    case (state)
      ST_COUNT: if (acc_in && item.last) state_next = ST_RD;
      ST_CLEAR: if (idx == 4'd15) state_next = ST_COUNT;
      // hold the read until the last pair updates have landed in the ram
      ST_RD:    if (!cmp_pend && !s1_v) state_next = ST_MUL;
      ST_MUL:   if (mstep == 2'd2) state_next = ST_DIV;
      ST_DIV:   if (zero_case || sat_case || bitn == 5'd0) state_next = ST_ACC;
      ST_ACC:   state_next = (idx == 4'd15) ? ST_DONE : ST_RD;
      ST_DONE:  state_next = ST_CLEAR;
      default:  state_next = ST_COUNT;
    endcase
  end

  always_comb begin
    rr_we = 1'b0;
    rr_wa = idx;
    rr_wd = wr;
    if (state == ST_CLEAR && clr_init) begin
      rr_we = 1'b1;
      rr_wd = '0;
    end else if (state == ST_ACC && ref_pass) begin
      rr_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx <= '0;
      clr_init <= 1'b1;
      prev <= NO_BASE;
      ccount <= '0;
      for (int i = 0; i < 4; i++) bcnt[i] <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      case (state)
        ST_COUNT: begin
          if (acc_in) begin
            if (ccount < MAXC) begin
              if (pair_ok) begin
                bcnt[prev[1:0]] <= bcnt[prev[1:0]] + CW'(1);
                bcnt[prev[1:0] ^ 2'd2] <= bcnt[prev[1:0] ^ 2'd2] + CW'(1);
              end
              prev <= code;
              ccount <= ccount + CW'(1);
            end
            if (item.last) begin
              ref_pass <= (item.opcode == OP_REFERENCE);
              idx <= '0;
              sum <= '0;
              len <= (ccount < MAXC) ? ccount + CW'(1) : ccount;
            end
          end
        end
        ST_CLEAR: begin
          idx <= idx + 4'd1;
          if (idx == 4'd15) clr_init <= 1'b0;
          prev <= NO_BASE;
          ccount <= '0;
          for (int i = 0; i < 4; i++) bcnt[i] <= '0;
        end
        ST_RD: begin
          if (idx == 4'd0 && prev != NO_BASE) begin
            bcnt[prev[1:0]] <= bcnt[prev[1:0]] + CW'(1);
            bcnt[prev[1:0] ^ 2'd2] <= bcnt[prev[1:0] ^ 2'd2] + CW'(1);
            prev <= NO_BASE;
          end
          mstep <= 2'd0;
        end
        ST_MUL: begin
          case (mstep)
            2'd0: begin
              d  <= pc_rd;
              b1 <= bcnt[idx[3:2]];
              b2 <= bcnt[idx[1:0]];
              p1 <= (2*CW)'(len) * (2*CW)'(len);
              p2 <= (2*CW)'(len - CW'(1)) * (2*CW)'(bcnt[idx[3:2]]);
              mstep <= 2'd1;
            end
            2'd1: begin
              pl1 <= (2*CW)'(p1[CW-1:0]) * (2*CW)'(d);
              pl2 <= (2*CW)'(p2[CW-1:0]) * (2*CW)'(b2);
              zero_case <= (d == '0) || (len < CW'(2));
              sat_case  <= (d != '0) && (len >= CW'(2)) && (b1 == '0 || b2 == '0);
              mstep <= 2'd2;
            end
            default: begin
              rem <= num_full;
              den <= den_full;
              bitn <= 5'(RATIO_W);
              q <= '0;
            end
          endcase
        end
        ST_DIV: begin
          if (zero_case) wr <= '0;
          else if (sat_case) wr <= RATIO_MAX;
          else begin
            if (!trial[NW+RATIO_W]) begin
              rem <= NW'(trial);
              if (bitn == 5'(RATIO_W)) begin
                sat_case <= 1'b1;
              end else begin
                q[bitn[4:0]] <= 1'b1;
              end
            end
            if (bitn != 5'd0) bitn <= bitn - 5'd1;
            else wr <= trial[NW+RATIO_W] ? q : (q | RATIO_W'(1));
          end
        end
        ST_ACC: begin
          sum <= sum + (RATIO_W+5)'(diff);
          idx <= idx + 4'd1;
        end
        ST_DONE: begin
          done <= !ref_pass;
          result.difference <= (len < CW'(2)) ? '0 : sum[RATIO_W+3:4];
          result.short_window <= (len < CW'(2));
          idx <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

### verif/tb_dinucleotide_abundance_difference.sv
// testbench for dinucleotide_abundance_difference: streams sequences, predicts
// the window difference in-line and checks every result beat; uses dnad_pkg
`timescale 1ns / 1ps
module tb_dinucleotide_abundance_difference;
  import dnad_pkg::*;

  localparam int LEN_CAP = 1048576;
  localparam int FRAC = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_item_t item = '0;
  logic busy;
  logic done;
  out_item_t result;

  dinucleotide_abundance_difference u_dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  in_item_t pending_items[$];
  out_item_t expected_diffs[$];
  int errors = 0;
  bit hold_sender = 1'b0;

  // predictor state
  logic [23:0] ref_ratio[16];
  longint pair_cnt[16];
  longint base_cnt[4];
  int prev_code;
  longint n_chars;

  function automatic int code_of(logic [7:0] c);
    case (c)
      "A": return 0;
      "C": return 1;
      "T": return 2;
      "G": return 3;
      default: return 4;
    endcase
  endfunction

  task automatic clear_counts();
    for (int i = 0; i < 16; i++) pair_cnt[i] = 0;
    for (int i = 0; i < 4; i++) base_cnt[i] = 0;
    prev_code = 4;
    n_chars = 0;
  endtask

  function automatic logic [23:0] abundance(int idx, longint len);
    logic [127:0] num, den;
    longint d, b1, b2;
    d = pair_cnt[idx];
    b1 = base_cnt[idx >> 2];
    b2 = base_cnt[idx & 3];
    if (d == 0 || len < 2) return 24'd0;
    if (b1 == 0 || b2 == 0) return RATIO_MAX;
    num = (128'(2 * len * len) * 128'(d)) << FRAC;
    den = 128'(len - 1) * 128'(b1) * 128'(b2);
    if (num >= (den << 24)) return RATIO_MAX;
    return 24'(num / den);
  endfunction

  task automatic predict_beat(in_item_t it);
    int c;
    longint len;
    longint sum;
    logic [23:0] w;
    out_item_t e;
    c = code_of(it.base_char);
    if (n_chars < LEN_CAP) begin
      if (prev_code < 4 && c < 4) begin
        base_cnt[prev_code]++;
        pair_cnt[prev_code * 4 + c]++;
        base_cnt[prev_code ^ 2]++;
        pair_cnt[(prev_code ^ 2) * 4 + (c ^ 2)]++;
      end
      prev_code = c;
      n_chars++;
    end
    if (!it.last) return;
    if (prev_code < 4) begin
      base_cnt[prev_code]++;
      base_cnt[prev_code ^ 2]++;
    end
    len = n_chars;
    if (it.opcode == OP_REFERENCE) begin
      for (int i = 0; i < 16; i++) ref_ratio[i] = abundance(i, len);
    end else begin
      if (len < 2) begin
        e.difference = '0;
        e.short_window = 1'b1;
      end else begin
        sum = 0;
        for (int i = 0; i < 16; i++) begin
          w = abundance(i, len);
          sum += (ref_ratio[i] >= w) ? longint'(ref_ratio[i] - w)
                                     : longint'(w - ref_ratio[i]);
        end
        e.difference = 24'(sum >> 4);
        e.short_window = 1'b0;
      end
      expected_diffs.push_back(e);
    end
    clear_counts();
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // beat acceptance is sampled at the rising edge and used by the driver
  // at the next falling edge
  logic accepted_q = 1'b0;
  always @(posedge clk) accepted_q <= start && !busy && !rst;

  // driver: bursts and gaps, changes on the falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (accepted_q) begin
        predict_beat(item);
        void'(pending_items.pop_front());
      end
      if (start && !accepted_q) begin
        // hold current beat
      end else if (hold_sender || pending_items.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
        end
        burst_left--;
        start <= 1'b1;
        item <= pending_items[0];
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_diffs.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        if (result.difference !== expected_diffs[0].difference)
          report_mismatch($sformatf("difference got %h exp %h",
            result.difference, expected_diffs[0].difference));
        if (result.short_window !== expected_diffs[0].short_window)
          report_mismatch($sformatf("short_window got %b exp %b",
            result.short_window, expected_diffs[0].short_window));
        void'(expected_diffs.pop_front());
      end
    end
  end

  function automatic logic [7:0] rand_char();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0, 1: return "A";
      2, 3: return "C";
      4, 5: return "T";
      6, 7: return "G";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_seq(bit op, int n, bit rich);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.opcode = op;
      it.base_char = rich ? rand_char() : 8'($urandom_range(0, 255));
      // occasional mixed opcode inside a pass
      if (i != n - 1 && $urandom_range(0, 15) == 0) it.opcode = ~op;
      it.last = (i == n - 1);
      pending_items.push_back(it);
    end
  endtask

  task automatic push_str(bit op, string s);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.opcode = op;
      it.base_char = s[i];
      it.last = (i == s.len() - 1);
      pending_items.push_back(it);
    end
  endtask

  initial begin
    int total;
    for (int i = 0; i < 16; i++) ref_ratio[i] = '0;
    clear_counts();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    // directed: window before any reference, short windows, extremes
    push_str(1'b1, "ACGT");
    push_str(1'b1, "A");
    push_str(1'b1, "AT");
    push_str(1'b0, "AACCGGTTAG");
    push_str(1'b1, "AACGTX");
    pending_items.push_back(in_item_t'{opcode: 1'b0, base_char: 8'hFF, last: 1'b0});
    pending_items.push_back(in_item_t'{opcode: 1'b0, base_char: 8'h00, last: 1'b1});
    push_str(1'b1, "AAAA");
    push_str(1'b0, "CCCC");
    push_str(1'b1, "CAGT");
    total = pending_items.size();
    // pause until all expected results are in
    wait (pending_items.size() == 0);
    hold_sender = 1'b1;
    wait (expected_diffs.size() == 0 && !busy);
    repeat (2) @(posedge clk);
    hold_sender = 1'b0;
    while (total < 800) begin
      int n;
      bit op;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 40);
      op = ($urandom_range(0, 2) != 0);
      push_seq(op, n, $urandom_range(0, 7) != 0);
      total += n;
    end
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (start || busy || expected_diffs.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0 && expected_diffs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

### sim.f
hw/rtl/dnad_pkg.sv
hw/rtl/dnad_ram.sv
hw/rtl/dinucleotide_abundance_difference.sv
verif/tb_dinucleotide_abundance_difference.sv
